// ===== hdl/trapezoidal_trajectory_sample_macros.svh =====
// ----------------------------------------------------------------------------
// Trapezoidal trajectory sampler: assertion macros
// Shared concurrent checks, clocked on clk and quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOIDAL_TRAJECTORY_SAMPLE_MACROS_SVH
`define TRAPEZOIDAL_TRAJECTORY_SAMPLE_MACROS_SVH

// Same-cycle implication.
`define TTS_CHECK_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trajectory sampler check failed");

// Next-cycle implication.
`define TTS_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trajectory sampler check failed");

`endif

// ===== hdl/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// Widths, codes and shared types of the trapezoidal trajectory sampler.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int FRAC_BITS = 16;

    localparam int DIST_W = 32;
    localparam int TIME_W = 24;
    localparam int MAG_W  = 32;

    // 20*e, 40*e - 3*T, 20*e - 17*T and 3*T, T^2
    localparam int E20_W = TIME_W + 5;
    localparam int A_W   = TIME_W + 6;
    localparam int U_W   = TIME_W + 2;
    localparam int SQ_W  = 2 * TIME_W;

    // velocity limit compare: 17*T scaled by 2^FRAC_BITS
    localparam int LIM_W = TIME_W + 5 + FRAC_BITS;

    localparam int NUM_W  = U_W + A_W;
    localparam int DEN_W  = 56;
    localparam int HALF_W = NUM_W / 2;
    localparam int PP_W   = MAG_W + HALF_W;
    localparam int PROD_W = MAG_W + NUM_W;
    localparam int QUO_W  = 40;
    localparam int DIV_LAT = QUO_W + 1;

    typedef enum logic [1:0] {
        STAT_RUN = 2'd0,
        STAT_END = 2'd1,
        STAT_ERR = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        SEG_UP,
        SEG_CRUISE,
        SEG_DOWN,
        SEG_END,
        SEG_ERR
    } seg_t;

    typedef struct packed {
        logic    neg;
        status_t status;
    } side_t;

endpackage

// ===== hdl/tts_div.sv =====
// ----------------------------------------------------------------------------
// tts_div
// Pipelined restoring divider: one quotient bit per stage, flags quotients
// that do not fit in QUO_W bits.
// ----------------------------------------------------------------------------
module tts_div (
    input  logic                        clk,
    input  logic                        adv,
    input  logic [tts_pkg::PROD_W-1:0]  prod,
    input  logic [tts_pkg::DEN_W-1:0]   den,
    output logic [tts_pkg::QUO_W-1:0]   quo,
    output logic [tts_pkg::DEN_W-1:0]   rem,
    output logic [tts_pkg::DEN_W-1:0]   den_out,
    output logic                        big
);
    import tts_pkg::*;

    logic [DEN_W-1:0] rem_reg [0:QUO_W];
    logic [DEN_W-1:0] den_reg [0:QUO_W];
    logic [QUO_W-1:0] low_reg [0:QUO_W];
    logic [QUO_W-1:0] quo_reg [0:QUO_W];
    logic             big_reg [0:QUO_W];

    logic [DEN_W-1:0] rem_next [1:QUO_W];
    logic             take_next [1:QUO_W];
    logic [DEN_W-1:0] head;

    assign head = {{(DEN_W - (PROD_W - QUO_W)){1'b0}}, prod[PROD_W-1:QUO_W]};

    always_comb
    begin
        logic [DEN_W:0] r2;
        r2 = '0;
        for (int k = 1; k <= QUO_W; k++)
        begin
            r2 = {rem_reg[k-1], low_reg[k-1][QUO_W-1]};
            take_next[k] = (r2 >= {1'b0, den_reg[k-1]});
            if (take_next[k])
            begin
                rem_next[k] = DEN_W'(r2 - {1'b0, den_reg[k-1]});
            end
            else
            begin
                rem_next[k] = r2[DEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // quotient bits above QUO_W only mean saturation
            big_reg[0] <= (head >= den);
            rem_reg[0] <= head;
            low_reg[0] <= prod[QUO_W-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            for (int k = 1; k <= QUO_W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= {low_reg[k-1][QUO_W-2:0], 1'b0};
                quo_reg[k] <= {quo_reg[k-1][QUO_W-2:0], take_next[k]};
                den_reg[k] <= den_reg[k-1];
                big_reg[k] <= big_reg[k-1];
            end
        end
    end

    assign quo     = quo_reg[QUO_W];
    assign rem     = rem_reg[QUO_W];
    assign den_out = den_reg[QUO_W];
    assign big     = big_reg[QUO_W];

endmodule

// ===== hdl/trapezoidal_trajectory_sample.sv =====
// ----------------------------------------------------------------------------
// trapezoidal_trajectory_sample
// Samples a trapezoidal move profile with parabolic blends.
// ----------------------------------------------------------------------------
// Input channel (sample_valid / sample_stall) carries one request: final
// distance (signed Q16.16), duration and elapsed time in ticks. Output
// channel (result_valid / result_stall) returns distance, velocity and
// status for each request, in order.
// A new request may enter every cycle while sample_stall is low;
// throughput is one sample per clock, set by the two 41-stage
// bit-per-stage dividers that run side by side.
// A skid register behind the output register keeps the pipeline moving
// while a result waits; sample_stall rises only once that skid register
// holds a result, and the whole pipeline then holds until it drains.
// Reset clears all valid bits; no request is in flight after reset.
// Status 2 (zero duration, or a positive distance whose peak velocity is
// above 1.0) zeroes both outputs; status 1 returns full distance, zero velocity.
// ----------------------------------------------------------------------------
`include "trapezoidal_trajectory_sample_macros.svh"

module trapezoidal_trajectory_sample (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  logic signed [tts_pkg::DIST_W-1:0] distance_final,
    input  logic        [tts_pkg::TIME_W-1:0] time_final,
    input  logic        [tts_pkg::TIME_W-1:0] time_elapsed,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic signed [tts_pkg::DIST_W-1:0] distance_now,
    output logic signed [tts_pkg::DIST_W-1:0] velocity_now,
    output logic        [1:0]                 status
);
    import tts_pkg::*;

    logic adv;

    // stage 1: inputs
    logic              v1_reg;
    logic [DIST_W-1:0] raw1_reg;
    logic [TIME_W-1:0] t1_reg, e1_reg;

    // stage 2: classify
    logic              neg_c, lim_c;
    logic [MAG_W-1:0]  mag_c;
    logic [LIM_W-1:0]  lim_lhs, lim_rhs;
    logic [E20_W-1:0]  e20_c, t3x_c, t17_c;
    seg_t              seg_c;
    status_t           stat_c;
    logic              v2_reg;
    side_t             side2_reg;
    seg_t              seg2_reg;
    logic [MAG_W-1:0]  mag2_reg;
    logic [TIME_W-1:0] t2_reg, e2_reg, tme2_reg;
    logic [A_W-1:0]    a2_reg;
    logic [U_W-1:0]    u2_reg, tx2_reg;

    // stage 3: squares and products
    logic              v3_reg;
    side_t             side3_reg;
    seg_t              seg3_reg;
    logic [MAG_W-1:0]  mag3_reg;
    logic [TIME_W-1:0] t3_reg, e3_reg, tme3_reg;
    logic [A_W-1:0]    a3_reg;
    logic [SQ_W-1:0]   ee3_reg, tt3_reg;
    logic [NUM_W-1:0]  p3_reg;
    logic [2*U_W-1:0]  uu3_reg;

    // stage 4: numerators and denominators
    logic [NUM_W-1:0]  nd_c, nv_c;
    logic [DEN_W-1:0]  dd_c, dv_c, tt51_c;
    logic              v4_reg;
    side_t             side4_reg;
    logic [MAG_W-1:0]  mag4_reg;
    logic [NUM_W-1:0]  nd4_reg, nv4_reg;
    logic [DEN_W-1:0]  dd4_reg, dv4_reg;

    // stage 5: partial products
    logic              v5_reg;
    side_t             side5_reg;
    logic [PP_W-1:0]   pdl5_reg, pdh5_reg, pvl5_reg, pvh5_reg;
    logic [DEN_W-1:0]  dd5_reg, dv5_reg;

    // stage 6: full products
    logic              v6_reg;
    side_t             side6_reg;
    logic [PROD_W-1:0] prod_d6_reg, prod_v6_reg;
    logic [DEN_W-1:0]  dd6_reg, dv6_reg;

    // dividers and side line
    logic [QUO_W-1:0]  quo_d, quo_v;
    logic [DEN_W-1:0]  rem_d, rem_v, den_d, den_v;
    logic              big_d, big_v;
    logic              vl_reg   [0:DIV_LAT-1];
    side_t             side_reg [0:DIV_LAT-1];

    // rounding and saturation
    logic              r1_v_reg, r2_v_reg, r3_v_reg;
    side_t             r1_side_reg, r2_side_reg;
    logic [QUO_W-1:0]  r1_qd_reg, r1_qv_reg;
    logic              r1_rd_reg, r1_rv_reg, r1_bd_reg, r1_bv_reg;
    logic [QUO_W:0]    r2_qd_reg, r2_qv_reg;
    logic              r2_bd_reg, r2_bv_reg;
    logic [DIST_W-1:0] r3_dist_reg, r3_vel_reg;
    status_t           r3_stat_reg;

    // output and skid
    logic              out_free;
    logic              out_err_c;
    logic              result_valid_reg, skid_v_reg;
    logic [DIST_W-1:0] out_dist_reg, out_vel_reg, skid_dist_reg, skid_vel_reg;
    status_t           out_stat_reg, skid_stat_reg;

    function automatic logic [DIST_W-1:0] sat_val(input logic [QUO_W:0] q,
                                                  input logic big,
                                                  input logic neg);
        logic [DIST_W-1:0] res;
        if (neg)
        begin
            if (big || (q >= (QUO_W+1)'({1'b1, {(DIST_W-1){1'b0}}})))
                res = {1'b1, {(DIST_W-1){1'b0}}};
            else
                res = ~q[DIST_W-1:0] + 1'b1;
        end
        else
        begin
            if (big || (q > (QUO_W+1)'({1'b0, {(DIST_W-1){1'b1}}})))
                res = {1'b0, {(DIST_W-1){1'b1}}};
            else
                res = q[DIST_W-1:0];
        end
        return res;
    endfunction

    assign adv          = !skid_v_reg;
    assign sample_stall = skid_v_reg;

    // ---------------- stage 2 logic ----------------
    always_comb
    begin
        neg_c   = raw1_reg[DIST_W-1];
        mag_c   = neg_c ? (~raw1_reg + 1'b1) : raw1_reg;
        lim_lhs = LIM_W'(raw1_reg[DIST_W-2:0]) * LIM_W'(40);
        lim_rhs = (LIM_W'(t1_reg) * LIM_W'(17)) << FRAC_BITS;
        // a negative distance never trips the velocity limit
        lim_c   = !neg_c && (lim_lhs > lim_rhs);
        e20_c   = E20_W'(e1_reg) * E20_W'(20);
        t3x_c   = E20_W'(t1_reg) * E20_W'(3);
        t17_c   = E20_W'(t1_reg) * E20_W'(17);
        if ((t1_reg == '0) || lim_c)
        begin
            seg_c  = SEG_ERR;
            stat_c = STAT_ERR;
        end
        else if (e1_reg >= t1_reg)
        begin
            seg_c  = SEG_END;
            stat_c = STAT_END;
        end
        else if (e20_c < t3x_c)
        begin
            seg_c  = SEG_UP;
            stat_c = STAT_RUN;
        end
        else if (e20_c < t17_c)
        begin
            seg_c  = SEG_CRUISE;
            stat_c = STAT_RUN;
        end
        else
        begin
            seg_c  = SEG_DOWN;
            stat_c = STAT_RUN;
        end
    end

    // ---------------- stage 4 logic ----------------
    always_comb
    begin
        tt51_c = DEN_W'(tt3_reg) * DEN_W'(51);
        nd_c   = '0;
        nv_c   = '0;
        dd_c   = DEN_W'(1);
        dv_c   = DEN_W'(1);
        case (seg3_reg)
            SEG_UP:
            begin
                nd_c = NUM_W'(ee3_reg) * NUM_W'(200);
                dd_c = tt51_c;
                nv_c = NUM_W'(e3_reg) * NUM_W'(800);
                dv_c = tt51_c;
            end
            SEG_CRUISE:
            begin
                nd_c = NUM_W'(a3_reg);
                dd_c = DEN_W'(t3_reg) * DEN_W'(34);
                nv_c = NUM_W'(40);
                dv_c = DEN_W'(t3_reg) * DEN_W'(17);
            end
            SEG_DOWN:
            begin
                nd_c = p3_reg - NUM_W'(uu3_reg);
                dd_c = tt51_c << 1;
                nv_c = NUM_W'(tme3_reg) * NUM_W'(800);
                dv_c = tt51_c;
            end
            SEG_END:
            begin
                // distance passes through as d * 1 / 1
                nd_c = NUM_W'(1);
            end
            default:
            begin
                nd_c = '0;
            end
        endcase
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++)
                vl_reg[k] <= 1'b0;
            r1_v_reg <= 1'b0;
            r2_v_reg <= 1'b0;
            r3_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg    <= sample_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            v6_reg    <= v5_reg;
            vl_reg[0] <= v6_reg;
            for (int k = 1; k < DIV_LAT; k++)
                vl_reg[k] <= vl_reg[k-1];
            r1_v_reg  <= vl_reg[DIV_LAT-1];
            r2_v_reg  <= r1_v_reg;
            r3_v_reg  <= r2_v_reg;
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            raw1_reg <= distance_final;
            t1_reg   <= time_final;
            e1_reg   <= time_elapsed;

            side2_reg <= '{neg: neg_c, status: stat_c};
            seg2_reg  <= seg_c;
            mag2_reg  <= mag_c;
            t2_reg    <= t1_reg;
            e2_reg    <= e1_reg;
            tme2_reg  <= t1_reg - e1_reg;
            a2_reg    <= A_W'(e1_reg) * A_W'(40) - A_W'(t3x_c);
            u2_reg    <= U_W'(e20_c - t17_c);
            tx2_reg   <= U_W'(t3x_c);

            side3_reg <= side2_reg;
            seg3_reg  <= seg2_reg;
            mag3_reg  <= mag2_reg;
            t3_reg    <= t2_reg;
            e3_reg    <= e2_reg;
            tme3_reg  <= tme2_reg;
            a3_reg    <= a2_reg;
            ee3_reg   <= SQ_W'(e2_reg) * SQ_W'(e2_reg);
            tt3_reg   <= SQ_W'(t2_reg) * SQ_W'(t2_reg);
            p3_reg    <= NUM_W'(tx2_reg) * NUM_W'(a2_reg);
            uu3_reg   <= (2*U_W)'(u2_reg) * (2*U_W)'(u2_reg);

            side4_reg <= side3_reg;
            mag4_reg  <= mag3_reg;
            nd4_reg   <= nd_c;
            nv4_reg   <= nv_c;
            dd4_reg   <= dd_c;
            dv4_reg   <= dv_c;

            side5_reg <= side4_reg;
            pdl5_reg  <= PP_W'(mag4_reg) * PP_W'(nd4_reg[HALF_W-1:0]);
            pdh5_reg  <= PP_W'(mag4_reg) * PP_W'(nd4_reg[NUM_W-1:HALF_W]);
            pvl5_reg  <= PP_W'(mag4_reg) * PP_W'(nv4_reg[HALF_W-1:0]);
            pvh5_reg  <= PP_W'(mag4_reg) * PP_W'(nv4_reg[NUM_W-1:HALF_W]);
            dd5_reg   <= dd4_reg;
            dv5_reg   <= dv4_reg;

            side6_reg   <= side5_reg;
            prod_d6_reg <= (PROD_W'(pdh5_reg) << HALF_W) + PROD_W'(pdl5_reg);
            prod_v6_reg <= (PROD_W'(pvh5_reg) << HALF_W) + PROD_W'(pvl5_reg);
            dd6_reg     <= dd5_reg;
            dv6_reg     <= dv5_reg;

            side_reg[0] <= side6_reg;
            for (int k = 1; k < DIV_LAT; k++)
                side_reg[k] <= side_reg[k-1];

            // round half away from zero on the magnitude
            r1_side_reg <= side_reg[DIV_LAT-1];
            r1_qd_reg   <= quo_d;
            r1_qv_reg   <= quo_v;
            r1_rd_reg   <= ({rem_d, 1'b0} >= {1'b0, den_d});
            r1_rv_reg   <= ({rem_v, 1'b0} >= {1'b0, den_v});
            r1_bd_reg   <= big_d;
            r1_bv_reg   <= big_v;

            r2_side_reg <= r1_side_reg;
            r2_qd_reg   <= (QUO_W+1)'(r1_qd_reg) + (QUO_W+1)'(r1_rd_reg);
            r2_qv_reg   <= (QUO_W+1)'(r1_qv_reg) + (QUO_W+1)'(r1_rv_reg);
            r2_bd_reg   <= r1_bd_reg;
            r2_bv_reg   <= r1_bv_reg;

            r3_dist_reg <= sat_val(r2_qd_reg, r2_bd_reg, r2_side_reg.neg);
            r3_vel_reg  <= sat_val(r2_qv_reg, r2_bv_reg, r2_side_reg.neg);
            r3_stat_reg <= r2_side_reg.status;
        end
    end

    tts_div u_div_dist (
        .clk     (clk),
        .adv     (adv),
        .prod    (prod_d6_reg),
        .den     (dd6_reg),
        .quo     (quo_d),
        .rem     (rem_d),
        .den_out (den_d),
        .big     (big_d)
    );

    tts_div u_div_vel (
        .clk     (clk),
        .adv     (adv),
        .prod    (prod_v6_reg),
        .den     (dv6_reg),
        .quo     (quo_v),
        .rem     (rem_v),
        .den_out (den_v),
        .big     (big_v)
    );

    // ---------------- output register and skid ----------------
    assign out_free = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_v_reg       <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_v_reg)
            begin
                result_valid_reg <= 1'b1;
                skid_v_reg       <= 1'b0;
            end
            else
            begin
                result_valid_reg <= r3_v_reg;
            end
        end
        else if (!skid_v_reg && r3_v_reg)
        begin
            // park the result while the output is held
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_v_reg)
            begin
                out_dist_reg <= skid_dist_reg;
                out_vel_reg  <= skid_vel_reg;
                out_stat_reg <= skid_stat_reg;
            end
            else
            begin
                out_dist_reg <= r3_dist_reg;
                out_vel_reg  <= r3_vel_reg;
                out_stat_reg <= r3_stat_reg;
            end
        end
        else if (!skid_v_reg)
        begin
            skid_dist_reg <= r3_dist_reg;
            skid_vel_reg  <= r3_vel_reg;
            skid_stat_reg <= r3_stat_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign distance_now = out_dist_reg;
    assign velocity_now = out_vel_reg;
    assign status       = out_stat_reg;

    assign out_err_c = result_valid_reg && (out_stat_reg == STAT_ERR);

    // ---------------- checks ----------------
    `TTS_CHECK_IMPLIES(a_skid_behind_out, skid_v_reg, result_valid_reg)
    `TTS_CHECK_IMPLIES(a_err_zero, out_err_c, (out_dist_reg == '0) && (out_vel_reg == '0))
    `TTS_CHECK_IMPLIES(a_end_still, result_valid_reg && (out_stat_reg == STAT_END), out_vel_reg == '0)
    `TTS_CHECK_NEXT(a_skid_fill, result_valid_reg && result_stall && !skid_v_reg && r3_v_reg, skid_v_reg)

endmodule
